// ----- rtl/ascii_command_frame_parser_unit_defines.svh -----
// Assertion macros shared by the parser modules.
`ifndef ASCII_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define ASCII_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

// Check that a property holds on every clock edge outside reset.
`define ACFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a property holds, with no reset qualification.
`define ACFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/acfp_pkg.sv -----
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types and constants of the ASCII command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none
package acfp_pkg;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_WS      = 3'd2;
  localparam logic [2:0] KIND_SS      = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  // One classified byte handed from front to back.
  typedef struct packed {
    logic       feed;     // deliver c as text
    logic       feed_gt;  // deliver a held-back '>' before c
    logic [7:0] c;
    logic       last;
    logic       frame_ok;
  } req_t;
endpackage
`default_nettype wire

// ----- rtl/acfp_front.sv -----
// ----------------------------------------------------------------------------
// acfp_front
// Framing checker: tracks the open/close bytes and CR/LF tail and tells the
// back end which text bytes to parse.
// ----------------------------------------------------------------------------
`default_nettype none
module acfp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             frame_last_i,
  output acfp_pkg::req_t        req_o,
  output logic                  push_o,
  input  wire logic             full_i,
  output logic                  stall_o
);
  logic [2:0] byte_count_q, byte_count_d;
  logic [2:0] count_last_q, count_last_d;
  logic       opened_q, opened_d;
  logic       close_q, close_d;
  logic       pend_q, pend_d;
  logic       crlf, gt, acc;

  assign stall_o = full_i;
  assign acc     = valid_i && !full_i;
  assign push_o  = acc;
  assign crlf    = (data_byte_i == 8'd13) || (data_byte_i == 8'd10);
  assign gt      = (data_byte_i == 8'h3E);

  always_comb begin
    byte_count_d = byte_count_q;
    count_last_d = count_last_q;
    opened_d     = opened_q;
    close_d      = close_q;
    pend_d       = pend_q;
    req_o        = '0;
    req_o.c      = data_byte_i;
    req_o.last   = frame_last_i;
    if (byte_count_q == 3'd0) begin
      opened_d = (data_byte_i == 8'h3C);
    end else if (gt) begin
      // feed only the older held '>'
      req_o.feed_gt = pend_q;
      pend_d        = 1'b1;
    end else if (crlf) begin
      req_o.feed = !pend_q;
    end else begin
      req_o.feed_gt = pend_q;
      req_o.feed    = 1'b1;
      pend_d        = 1'b0;
    end
    if (!crlf) begin
      close_d      = gt;
      count_last_d = (byte_count_q < 3'd4) ? byte_count_q + 3'd1 : 3'd4;
    end
    if (byte_count_q < 3'd4) byte_count_d = byte_count_q + 3'd1;
    req_o.frame_ok = opened_d && close_d && (count_last_d >= 3'd4);
    if (frame_last_i) begin
      byte_count_d = '0;
      count_last_d = '0;
      opened_d     = 1'b0;
      close_d      = 1'b0;
      pend_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      count_last_q <= '0;
      opened_q     <= 1'b0;
      close_q      <= 1'b0;
      pend_q       <= 1'b0;
    end else if (acc) begin
      byte_count_q <= byte_count_d;
      count_last_q <= count_last_d;
      opened_q     <= opened_d;
      close_q      <= close_d;
      pend_q       <= pend_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/acfp_queue.sv -----
// ----------------------------------------------------------------------------
// acfp_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_command_frame_parser_unit_defines.svh"
module acfp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire acfp_pkg::req_t req_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output acfp_pkg::req_t      req_o
);
  acfp_pkg::req_t                 mem_q [acfp_pkg::QDepth];
  logic [acfp_pkg::QPtrW-1:0]     wp_q, rp_q;
  logic [acfp_pkg::QPtrW:0]       cnt_q;

  assign full_o  = (cnt_q == (acfp_pkg::QPtrW+1)'(acfp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign req_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (acfp_pkg::QPtrW+1)'(push_i) - (acfp_pkg::QPtrW+1)'(pop_i);
    end
  end

  `ACFP_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "queue overflow")
  `ACFP_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o), "queue underflow")
  `ACFP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= (acfp_pkg::QPtrW+1)'(acfp_pkg::QDepth),
    "queue count out of range")
endmodule
`default_nettype wire

// ----- rtl/acfp_back.sv -----
// ----------------------------------------------------------------------------
// acfp_back
// Token parser: command word matcher and three saturating atol-style numbers.
// A held '>' is taken before the current byte, which may wait if it ends the frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_command_frame_parser_unit_defines.svh"
module acfp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire acfp_pkg::req_t req_i,
  output logic                pop_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output logic                frame_ok_o,
  output logic [2:0]          command_kind_o,
  output logic signed [31:0]  length_value_o,
  output logic signed [31:0]  first_value_o,
  output logic signed [31:0]  second_value_o
);
  localparam logic [3:0] WM_EMPTY = 4'd0, WM_S = 4'd1, WM_ST = 4'd2, WM_STA = 4'd3,
    WM_STAR = 4'd4, WM_START = 4'd5, WM_STO = 4'd6, WM_STOP = 4'd7, WM_W = 4'd8,
    WM_WS = 4'd9, WM_SS = 4'd10, WM_DEAD = 4'd11;
  localparam logic [1:0] PH_SKIP = 2'd0, PH_SIGN = 2'd1, PH_DIGITS = 2'd2, PH_DONE = 2'd3;

  logic [1:0]  tok_q, tok_d;
  logic [3:0]  wm_q, wm_d;
  logic [1:0]  ph_q, ph_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q [3];
  logic [31:0] acc_d [3];
  logic        fp_q, fp_d, sp_q, sp_d;
  logic        gt_done_q;
  logic        busy, step_gt, finish, out_free;
  logic [7:0]  ch, lc;
  logic        digit, space;
  logic [31:0] cur;
  logic signed [35:0] prod;
  logic signed [35:0] nv;
  logic [31:0] sat;
  logic [1:0]  ai;

  assign out_free = !valid_o || !stall_i;
  // only the last byte of a frame has to wait for the output register
  assign busy     = !empty_i && (out_free || !req_i.last);
  assign step_gt  = req_i.feed_gt && !gt_done_q;
  assign finish   = busy && !step_gt;
  assign pop_o    = finish;
  assign ch       = step_gt ? 8'h3E : req_i.c;
  assign lc       = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
  assign digit    = (ch >= 8'h30) && (ch <= 8'h39);
  assign space    = (ch == 8'h20) || (ch >= 8'd9 && ch <= 8'd13);
  assign ai       = (tok_q == 2'd0) ? 2'd0 : tok_q - 2'd1;
  assign cur      = acc_q[ai];
  // times ten as shift-adds, then saturate
  assign prod = ($signed({{4{cur[31]}}, cur}) <<< 3) + ($signed({{4{cur[31]}}, cur}) <<< 1);
  assign nv   = neg_q ? prod - 36'(ch - 8'h30) : prod + 36'(ch - 8'h30);
  assign sat  = (nv > 36'sd2147483647) ? 32'h7FFFFFFF :
                (nv < -36'sd2147483648) ? 32'h80000000 : nv[31:0];

  function automatic logic [3:0] word_next(input logic [3:0] st, input logic [7:0] c);
    logic [3:0] r;
    r = WM_DEAD;
    unique case (st)
      WM_EMPTY: r = (c == 8'h73) ? WM_S : ((c == 8'h77) ? WM_W : WM_DEAD);
      WM_S:     r = (c == 8'h74) ? WM_ST : ((c == 8'h73) ? WM_SS : WM_DEAD);
      WM_ST:    r = (c == 8'h61) ? WM_STA : ((c == 8'h6F) ? WM_STO : WM_DEAD);
      WM_STA:   r = (c == 8'h72) ? WM_STAR : WM_DEAD;
      WM_STAR:  r = (c == 8'h74) ? WM_START : WM_DEAD;
      WM_STO:   r = (c == 8'h70) ? WM_STOP : WM_DEAD;
      WM_W:     r = (c == 8'h73) ? WM_WS : WM_DEAD;
      default:  r = WM_DEAD;
    endcase
    return r;
  endfunction

  always_comb begin
    tok_d = tok_q; wm_d = wm_q; ph_d = ph_q; neg_d = neg_q;
    acc_d = acc_q; fp_d = fp_q; sp_d = sp_q;
    if (busy && (step_gt || req_i.feed)) begin
      if (tok_q == 2'd2) fp_d = 1'b1;
      if (tok_q == 2'd3) sp_d = 1'b1;
      if (ch == 8'h2C && tok_q != 2'd3) begin
        tok_d = tok_q + 2'd1; ph_d = PH_SKIP; neg_d = 1'b0;
      end else if (tok_q == 2'd0) begin
        wm_d = word_next(wm_q, lc);
      end else begin
        priority if (ph_q == PH_DONE) begin
        end else if (ph_q == PH_SKIP && space) begin
        end else if (ph_q == PH_SKIP && (ch == 8'h2B || ch == 8'h2D)) begin
          neg_d = (ch == 8'h2D); ph_d = PH_SIGN;
        end else if (digit) begin
          ph_d = PH_DIGITS; acc_d[ai] = sat;
        end else begin
          ph_d = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0; wm_q <= WM_EMPTY; ph_q <= PH_SKIP; neg_q <= 1'b0;
      acc_q <= '{default: '0}; fp_q <= 1'b0; sp_q <= 1'b0;
      gt_done_q <= 1'b0; valid_o <= 1'b0;
    end else begin
      if (busy) gt_done_q <= step_gt;
      if (finish && req_i.last) begin
        tok_q <= '0; wm_q <= WM_EMPTY; ph_q <= PH_SKIP; neg_q <= 1'b0;
        acc_q <= '{default: '0}; fp_q <= 1'b0; sp_q <= 1'b0;
        valid_o <= 1'b1;
      end else begin
        tok_q <= tok_d; wm_q <= wm_d; ph_q <= ph_d; neg_q <= neg_d;
        acc_q <= acc_d; fp_q <= fp_d; sp_q <= sp_d;
        if (!stall_i) valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish && req_i.last) begin
      frame_ok_o <= req_i.frame_ok;
      if (req_i.frame_ok) begin
        unique case (wm_d)
          WM_START: command_kind_o <= acfp_pkg::KIND_START;
          WM_STOP:  command_kind_o <= acfp_pkg::KIND_STOP;
          WM_WS:    command_kind_o <= acfp_pkg::KIND_WS;
          WM_SS:    command_kind_o <= acfp_pkg::KIND_SS;
          default:  command_kind_o <= acfp_pkg::KIND_UNKNOWN;
        endcase
        length_value_o <= acc_d[0];
        first_value_o  <= fp_d ? acc_d[1] : 32'hFFFFFFFF;
        second_value_o <= sp_d ? acc_d[2] : 32'hFFFFFFFF;
      end else begin
        command_kind_o <= '0; length_value_o <= '0;
        first_value_o  <= '0; second_value_o <= '0;
      end
    end
  end

  `ACFP_ASSERT(a_hold, clk_i, rst_ni, (valid_o && stall_i) |=> valid_o, "result dropped")
  `ACFP_ASSERT(a_gt_then_pop, clk_i, rst_ni, (busy && step_gt) |=> (!empty_i && gt_done_q),
    "held close byte lost")
  `ACFP_ASSERT(a_bad_zero, clk_i, rst_ni, (valid_o && !frame_ok_o) |-> (command_kind_o == '0),
    "bad frame fields not zero")
endmodule
`default_nettype wire

// ----- rtl/ascii_command_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ascii_command_frame_parser_unit
// Parses "<cmd,len,v1,v2>" frames byte by byte and reports the fields.
// ----------------------------------------------------------------------------
// One byte per cycle is accepted while the request queue is not full. A
// byte that releases a held-back '>' into the text (a following '>' or any
// other non-CR/LF byte) is handled by the back-end parser as the '>' first
// and then the byte itself; a two-entry request queue absorbs this, so such
// bytes may briefly stall the input. An accepted byte is written into the
// queue and parsed from there. One result is given per frame, registered
// when its last byte leaves the queue. It waits in the output register
// until taken; meanwhile the parser keeps working and holds only when the
// next frame's last byte reaches it.
`default_nettype none
module ascii_command_frame_parser_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          frame_last_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic               frame_ok_o,
  output logic [2:0]         command_kind_o,
  output logic signed [31:0] length_value_o,
  output logic signed [31:0] first_value_o,
  output logic signed [31:0] second_value_o
);
  acfp_pkg::req_t freq, breq;
  logic push, full, pop, empty;

  acfp_front u_front (.clk_i, .rst_ni, .valid_i, .data_byte_i, .frame_last_i,
    .req_o(freq), .push_o(push), .full_i(full), .stall_o);
  acfp_queue u_queue (.clk_i, .rst_ni, .push_i(push), .req_i(freq), .full_o(full),
    .pop_i(pop), .empty_o(empty), .req_o(breq));
  acfp_back u_back (.clk_i, .rst_ni, .empty_i(empty), .req_i(breq), .pop_o(pop),
    .valid_o, .stall_i, .frame_ok_o, .command_kind_o, .length_value_o,
    .first_value_o, .second_value_o);
endmodule
`default_nettype wire
